FILE: rtl/core/rrcp_pkg.sv
// Shared widths and request types for the ray-ray closest point core.
package rrcp_pkg;

  localparam int Q_W    = 32;            // quotient (ray parameter) width
  localparam int DEN_W  = 72;            // divider denominator width
  localparam int NUM_W  = 88;            // divider numerator width
  localparam int REM_W  = DEN_W + Q_W;   // partial remainder width
  localparam int SUM_W  = 53;            // dot product width, signed
  localparam int MAG_W  = 52;            // dot product magnitude width
  localparam int HALF_W = MAG_W / 2;     // partial product operand width
  localparam int PROD_W = 2 * MAG_W;     // product of two dot products, magnitude

  typedef struct packed {
    logic [2:0][31:0] o0;
    logic [2:0][31:0] o1;
    logic [2:0][17:0] d0;
    logic [2:0][17:0] d1;
  } geo_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    logic             zero;
    logic             sat;
  } lane_t;

  // lane 0 carries s, lane 1 carries t
  typedef struct packed {
    geo_t            geo;
    lane_t [1:0]     lane;
  } dstage_t;

endpackage

FILE: rtl/core/rrcp_div.sv
// Radix-2 restoring divider pipeline, one quotient bit per stage, two lanes.
module rrcp_div import rrcp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    vld_i,
  input  dstage_t req_i,
  output logic    vld_o,
  output dstage_t res_o
);

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    dstage_t          cur;
    dstage_t          nxt;
    logic             cur_vld;
    logic [REM_W-1:0] dsh [2];
    logic             vld_q;
    dstage_t          stg_q;

    if (k == 0) begin : g_first
      assign cur     = req_i;
      assign cur_vld = vld_i;
    end else begin : g_next
      assign cur     = g_stage[k-1].stg_q;
      assign cur_vld = g_stage[k-1].vld_q;
    end

    always_comb begin
      nxt = cur;
      for (int l = 0; l < 2; l++) begin
        dsh[l] = REM_W'(cur.lane[l].den) << (Q_W - 1 - k);
        if (cur.lane[l].rem >= dsh[l]) begin
          nxt.lane[l].rem              = cur.lane[l].rem - dsh[l];
          nxt.lane[l].quo[Q_W - 1 - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q <= nxt;
    end
  end

  assign vld_o = g_stage[Q_W-1].vld_q;
  assign res_o = g_stage[Q_W-1].stg_q;

endmodule

FILE: rtl/core/ray_ray_closest_points_core.sv
// Ray-ray closest approach: pipelined dot products, products, divides and outputs.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------------
//  request   | start / busy              | first_*, second_* origins and directions
//  result    | done_o (one-cycle strobe) | dist_squared_o, *_param_o, near*_o
//  config    | APB psel/penable/pwrite   | parallel_threshold at byte address 0
//
//  One request per cycle; busy stays low. The longest part of the pipeline is
//  the 32-stage restoring divider (one quotient bit per stage).
//  Reset clears the valid chain and sets parallel_threshold to 1.
//  Results leave as a strobe; nothing in the pipe ever waits.
module ray_ray_closest_points_core import rrcp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_origin_x_i,
  input  logic signed [31:0] first_origin_y_i,
  input  logic signed [31:0] first_origin_z_i,
  input  logic signed [17:0] first_dir_x_i,
  input  logic signed [17:0] first_dir_y_i,
  input  logic signed [17:0] first_dir_z_i,
  input  logic signed [31:0] second_origin_x_i,
  input  logic signed [31:0] second_origin_y_i,
  input  logic signed [31:0] second_origin_z_i,
  input  logic signed [17:0] second_dir_x_i,
  input  logic signed [17:0] second_dir_y_i,
  input  logic signed [17:0] second_dir_z_i,
  output logic               done_o,
  output logic [47:0]        dist_squared_o,
  output logic [31:0]        first_param_o,
  output logic [31:0]        second_param_o,
  output logic signed [31:0] near0_x_o,
  output logic signed [31:0] near0_y_o,
  output logic signed [31:0] near0_z_o,
  output logic signed [31:0] near1_x_o,
  output logic signed [31:0] near1_y_o,
  output logic signed [31:0] near1_z_o
);

  localparam logic REG_THR = 1'b0;
  localparam int   EXT_W   = PROD_W + 2;
  localparam int   SAT_W   = NUM_W + FRAC_BITS + Q_W;
  localparam int   NP_W    = ((32 + FRAC_BITS) > 51 ? 32 + FRAC_BITS : 51) + 1;
  localparam int   WC_W    = ((33 + FRAC_BITS) > 51 ? 33 + FRAC_BITS : 51) + 2;
  localparam int   WCM_W   = WC_W - 1;
  localparam int   H_W     = (WCM_W + 1) / 2;
  localparam int   HI_W    = WCM_W - H_W;
  localparam int   SQ_W    = 2 * WCM_W;
  localparam int   ACC_W   = SQ_W + 2;
  localparam int   LAT     = 9 + Q_W + 6;
  localparam logic [47:0] DIST_MAX = '1;

  // product slots
  localparam int P_AC = 0;
  localparam int P_BB = 1;
  localparam int P_BE = 2;
  localparam int P_CD = 3;
  localparam int P_AE = 4;
  localparam int P_BD = 5;

  function automatic logic [31:0] sat_s32(input logic signed [NP_W-1:0] v);
    logic signed [NP_W-1:0] hi_l;
    logic signed [NP_W-1:0] lo_l;
    hi_l = $signed({{(NP_W-31){1'b0}}, {31{1'b1}}});
    lo_l = $signed({{(NP_W-31){1'b1}}, {31{1'b0}}});
    if (v > hi_l) return 32'h7fff_ffff;
    else if (v < lo_l) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  // ---------------- configuration ----------------
  logic [31:0] thr_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THR);
  assign prdata = (paddr[2] == REG_THR) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 32'd1;
    end else if (cfg_wr) begin
      thr_q <= pwdata;
    end
  end

  // ---------------- valid chains ----------------
  logic [9:1] fv_q;
  logic [6:1] pv_q;
  logic       dres_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      pv_q <= '0;
    end else begin
      fv_q <= {fv_q[8:1], start && !busy};
      pv_q <= {pv_q[5:1], dres_vld};
    end
  end

  // ---------------- stage 1: capture request ----------------
  geo_t geo1_q, geo2_q, geo3_q, geo4_q, geo5_q, geo6_q, geo7_q, geo8_q;

  always_ff @(posedge clk_i) begin
    geo1_q.o0 <= {first_origin_z_i, first_origin_y_i, first_origin_x_i};
    geo1_q.o1 <= {second_origin_z_i, second_origin_y_i, second_origin_x_i};
    geo1_q.d0 <= {first_dir_z_i, first_dir_y_i, first_dir_x_i};
    geo1_q.d1 <= {second_dir_z_i, second_dir_y_i, second_dir_x_i};
  end

  // ---------------- stage 2: per-axis products ----------------
  logic signed [32:0] w2 [3];
  logic signed [35:0] aa2_q [3], bb2_q [3], cc2_q [3];
  logic signed [50:0] dd2_q [3], ee2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w2[i] = 33'($signed(geo1_q.o0[i])) - 33'($signed(geo1_q.o1[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      aa2_q[i] <= $signed(geo1_q.d0[i]) * $signed(geo1_q.d0[i]);
      bb2_q[i] <= $signed(geo1_q.d0[i]) * $signed(geo1_q.d1[i]);
      cc2_q[i] <= $signed(geo1_q.d1[i]) * $signed(geo1_q.d1[i]);
      dd2_q[i] <= $signed(geo1_q.d0[i]) * w2[i];
      ee2_q[i] <= $signed(geo1_q.d1[i]) * w2[i];
    end
    geo2_q <= geo1_q;
  end

  // ---------------- stage 3: dot products ----------------
  logic signed [SUM_W-1:0] a3_q, b3_q, c3_q, d3_q, e3_q;

  always_ff @(posedge clk_i) begin
    a3_q   <= SUM_W'(aa2_q[0]) + SUM_W'(aa2_q[1]) + SUM_W'(aa2_q[2]);
    b3_q   <= SUM_W'(bb2_q[0]) + SUM_W'(bb2_q[1]) + SUM_W'(bb2_q[2]);
    c3_q   <= SUM_W'(cc2_q[0]) + SUM_W'(cc2_q[1]) + SUM_W'(cc2_q[2]);
    d3_q   <= SUM_W'(dd2_q[0]) + SUM_W'(dd2_q[1]) + SUM_W'(dd2_q[2]);
    e3_q   <= SUM_W'(ee2_q[0]) + SUM_W'(ee2_q[1]) + SUM_W'(ee2_q[2]);
    geo3_q <= geo2_q;
  end

  // ---------------- stage 4: operand magnitudes ----------------
  logic signed [SUM_W-1:0] xs4 [6], ys4 [6];
  logic signed [SUM_W-1:0] xa4 [6], ya4 [6];
  logic [MAG_W-1:0]        xm4_q [6], ym4_q [6];
  logic [5:0]              neg4_q, neg5_q;
  logic signed [SUM_W-1:0] a4_q, c4_q, d4_q, e4_q, a5_q, c5_q, d5_q, e5_q;
  logic signed [SUM_W-1:0] a6_q, c6_q, d6_q, e6_q, a7_q, c7_q, d7_q, e7_q;

  always_comb begin
    xs4[P_AC] = a3_q; ys4[P_AC] = c3_q;
    xs4[P_BB] = b3_q; ys4[P_BB] = b3_q;
    xs4[P_BE] = b3_q; ys4[P_BE] = e3_q;
    xs4[P_CD] = c3_q; ys4[P_CD] = d3_q;
    xs4[P_AE] = a3_q; ys4[P_AE] = e3_q;
    xs4[P_BD] = b3_q; ys4[P_BD] = d3_q;
    for (int j = 0; j < 6; j++) begin
      xa4[j] = xs4[j][SUM_W-1] ? -xs4[j] : xs4[j];
      ya4[j] = ys4[j][SUM_W-1] ? -ys4[j] : ys4[j];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      xm4_q[j]  <= xa4[j][MAG_W-1:0];
      ym4_q[j]  <= ya4[j][MAG_W-1:0];
      neg4_q[j] <= xs4[j][SUM_W-1] ^ ys4[j][SUM_W-1];
    end
    a4_q <= a3_q; c4_q <= c3_q; d4_q <= d3_q; e4_q <= e3_q;
    geo4_q <= geo3_q;
  end

  // ---------------- stage 5: partial products ----------------
  logic [MAG_W-1:0] pp5_q [6][4];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      pp5_q[j][0] <= xm4_q[j][HALF_W-1:0] * ym4_q[j][HALF_W-1:0];
      pp5_q[j][1] <= xm4_q[j][HALF_W-1:0] * ym4_q[j][MAG_W-1:HALF_W];
      pp5_q[j][2] <= xm4_q[j][MAG_W-1:HALF_W] * ym4_q[j][HALF_W-1:0];
      pp5_q[j][3] <= xm4_q[j][MAG_W-1:HALF_W] * ym4_q[j][MAG_W-1:HALF_W];
    end
    neg5_q <= neg4_q;
    a5_q <= a4_q; c5_q <= c4_q; d5_q <= d4_q; e5_q <= e4_q;
    geo5_q <= geo4_q;
  end

  // ---------------- stage 6: combine and sign ----------------
  logic [PROD_W-1:0]     pm6 [6];
  logic signed [PROD_W:0] pe6 [6];
  logic signed [PROD_W:0] prod6_q [6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      pm6[j] = PROD_W'(pp5_q[j][0])
             + ((PROD_W'(pp5_q[j][1]) + PROD_W'(pp5_q[j][2])) << HALF_W)
             + (PROD_W'(pp5_q[j][3]) << MAG_W);
      pe6[j] = $signed({1'b0, pm6[j]});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      prod6_q[j] <= neg5_q[j] ? -pe6[j] : pe6[j];
    end
    a6_q <= a5_q; c6_q <= c5_q; d6_q <= d5_q; e6_q <= e5_q;
    geo6_q <= geo5_q;
  end

  // ---------------- stage 7: denominator and numerators ----------------
  logic signed [EXT_W-1:0] den7_q, sn7_q, tn7_q;

  always_ff @(posedge clk_i) begin
    den7_q <= EXT_W'(prod6_q[P_AC]) - EXT_W'(prod6_q[P_BB]);
    sn7_q  <= EXT_W'(prod6_q[P_BE]) - EXT_W'(prod6_q[P_CD]);
    tn7_q  <= EXT_W'(prod6_q[P_AE]) - EXT_W'(prod6_q[P_BD]);
    a7_q <= a6_q; c7_q <= c6_q; d7_q <= d6_q; e7_q <= e6_q;
    geo7_q <= geo6_q;
  end

  // ---------------- stage 8: case selection ----------------
  logic signed [EXT_W-1:0] thr8, ae8, ce8, de8, ee8;
  logic signed [EXT_W-1:0] sn8, sd8, tn8, td8;
  logic                    par8, zs8, zt8;
  logic [NUM_W-1:0]        snum8_q, tnum8_q;
  logic [DEN_W-1:0]        sden8_q, tden8_q;
  logic                    zs8_q, zt8_q;

  always_comb begin
    thr8 = $signed(EXT_W'({1'b0, thr_q}));
    ae8  = EXT_W'(a7_q);
    ce8  = EXT_W'(c7_q);
    de8  = EXT_W'(d7_q);
    ee8  = EXT_W'(e7_q);
    par8 = (den7_q <= thr8) && (den7_q >= -thr8);
    zs8  = 1'b0;
    if (par8) begin
      sd8 = ce8; td8 = ce8; sn8 = '0; tn8 = ee8;
    end else begin
      sd8 = den7_q; td8 = den7_q; sn8 = sn7_q; tn8 = tn7_q;
      if (sn7_q < 0) begin
        sn8 = '0; tn8 = ee8; td8 = ce8;
      end
    end
    // negative t: clamp t, take s from the origin offset along ray0, or zero s if that is negative
    zt8 = (tn8 < 0) || (td8 <= 0);
    if (tn8 < 0) begin
      if (de8 > 0) begin
        zs8 = 1'b1;
      end else begin
        sn8 = -de8;
        sd8 = ae8;
      end
    end
    zs8 = zs8 || (sn8 < 0) || (sd8 <= 0);
  end

  always_ff @(posedge clk_i) begin
    snum8_q <= sn8[NUM_W-1:0];
    tnum8_q <= tn8[NUM_W-1:0];
    sden8_q <= sd8[DEN_W-1:0];
    tden8_q <= td8[DEN_W-1:0];
    zs8_q   <= zs8;
    zt8_q   <= zt8;
    geo8_q  <= geo7_q;
  end

  // ---------------- stage 9: divider setup ----------------
  logic [SAT_W-1:0] nsh9 [2], dsh9 [2];
  logic [NUM_W-1:0] num9 [2];
  logic [DEN_W-1:0] den9 [2];
  dstage_t          dreq_d, dreq_q, dres;

  always_comb begin
    num9[0] = snum8_q; num9[1] = tnum8_q;
    den9[0] = sden8_q; den9[1] = tden8_q;
    dreq_d.geo = geo8_q;
    for (int l = 0; l < 2; l++) begin
      nsh9[l] = SAT_W'(num9[l]) << FRAC_BITS;
      dsh9[l] = SAT_W'(den9[l]) << Q_W;
      dreq_d.lane[l].rem = nsh9[l][REM_W-1:0];
      dreq_d.lane[l].den = den9[l];
      dreq_d.lane[l].quo = '0;
      dreq_d.lane[l].sat = nsh9[l] >= dsh9[l];
    end
    dreq_d.lane[0].zero = zs8_q;
    dreq_d.lane[1].zero = zt8_q;
  end

  always_ff @(posedge clk_i) begin
    dreq_q <= dreq_d;
  end

  rrcp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fv_q[9]),
    .req_i  (dreq_q),
    .vld_o  (dres_vld),
    .res_o  (dres)
  );

  // ---------------- post 1: final parameters, direction scaling ----------------
  logic [Q_W-1:0]     q1 [2];
  logic [Q_W-1:0]     s1_q, t1_q, s2_q, t2_q, s3_q, t3_q, s4_q, t4_q, s5_q, t5_q;
  logic signed [50:0] sp1_q [3], tp1_q [3];
  geo_t               gp1_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dres.lane[l].zero) q1[l] = '0;
      else if (dres.lane[l].sat) q1[l] = '1;
      else q1[l] = dres.lane[l].quo;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sp1_q[i] <= $signed({1'b0, q1[0]}) * $signed(dres.geo.d0[i]);
      tp1_q[i] <= $signed({1'b0, q1[1]}) * $signed(dres.geo.d1[i]);
    end
    s1_q  <= q1[0];
    t1_q  <= q1[1];
    gp1_q <= dres.geo;
  end

  // ---------------- post 2: offset vector and closest points ----------------
  logic signed [NP_W-1:0] n0p2 [3], n1p2 [3];
  logic signed [NP_W-1:0] n0s2 [3], n1s2 [3];
  logic signed [WC_W-1:0] wc2 [3];
  logic signed [WC_W-1:0] wc2_q [3];
  logic [31:0]            n0_2_q [3], n1_2_q [3], n0_3_q [3], n1_3_q [3];
  logic [31:0]            n0_4_q [3], n1_4_q [3], n0_5_q [3], n1_5_q [3];
  logic [31:0]            n0_6_q [3], n1_6_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n0p2[i] = (NP_W'($signed(gp1_q.o0[i])) <<< FRAC_BITS) + NP_W'(sp1_q[i]);
      n1p2[i] = (NP_W'($signed(gp1_q.o1[i])) <<< FRAC_BITS) + NP_W'(tp1_q[i]);
      n0s2[i] = n0p2[i] >>> FRAC_BITS;
      n1s2[i] = n1p2[i] >>> FRAC_BITS;
      wc2[i]  = ((WC_W'($signed(gp1_q.o0[i])) - WC_W'($signed(gp1_q.o1[i])))
                 <<< FRAC_BITS) + WC_W'(sp1_q[i]) - WC_W'(tp1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      wc2_q[i]  <= wc2[i];
      n0_2_q[i] <= sat_s32(n0s2[i]);
      n1_2_q[i] <= sat_s32(n1s2[i]);
    end
    s2_q <= s1_q;
    t2_q <= t1_q;
  end

  // ---------------- post 3..5: squares of the offset components ----------------
  logic signed [WC_W-1:0]     wca3 [3];
  logic [WCM_W-1:0]           wcm3_q [3];
  logic [2*H_W-1:0]           ll4_q [3];
  logic [H_W+HI_W-1:0]        lh4_q [3];
  logic [2*HI_W-1:0]          hh4_q [3];
  logic [SQ_W-1:0]            sq5_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wca3[i] = wc2_q[i][WC_W-1] ? -wc2_q[i] : wc2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      wcm3_q[i] <= wca3[i][WCM_W-1:0];
      ll4_q[i]  <= wcm3_q[i][H_W-1:0] * wcm3_q[i][H_W-1:0];
      lh4_q[i]  <= wcm3_q[i][H_W-1:0] * wcm3_q[i][WCM_W-1:H_W];
      hh4_q[i]  <= wcm3_q[i][WCM_W-1:H_W] * wcm3_q[i][WCM_W-1:H_W];
      sq5_q[i]  <= SQ_W'(ll4_q[i]) + (SQ_W'(lh4_q[i]) << (H_W + 1))
                 + (SQ_W'(hh4_q[i]) << (2 * H_W));
      n0_3_q[i] <= n0_2_q[i]; n1_3_q[i] <= n1_2_q[i];
      n0_4_q[i] <= n0_3_q[i]; n1_4_q[i] <= n1_3_q[i];
      n0_5_q[i] <= n0_4_q[i]; n1_5_q[i] <= n1_4_q[i];
      n0_6_q[i] <= n0_5_q[i]; n1_6_q[i] <= n1_5_q[i];
    end
    s3_q <= s2_q; t3_q <= t2_q;
    s4_q <= s3_q; t4_q <= t3_q;
    s5_q <= s4_q; t5_q <= t4_q;
  end

  // ---------------- post 6: distance and result registers ----------------
  logic [ACC_W-1:0] acc6, accsh6;
  logic [47:0]      dist6_q;
  logic [31:0]      s6_q, t6_q;

  always_comb begin
    acc6   = ACC_W'(sq5_q[0]) + ACC_W'(sq5_q[1]) + ACC_W'(sq5_q[2]);
    accsh6 = acc6 >> (3 * FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    dist6_q <= (accsh6 > ACC_W'(DIST_MAX)) ? DIST_MAX : accsh6[47:0];
    s6_q    <= s5_q;
    t6_q    <= t5_q;
  end

  assign done_o         = pv_q[6];
  assign dist_squared_o = dist6_q;
  assign first_param_o  = s6_q;
  assign second_param_o = t6_q;
  assign near0_x_o      = n0_6_q[0];
  assign near0_y_o      = n0_6_q[1];
  assign near0_z_o      = n0_6_q[2];
  assign near1_x_o      = n1_6_q[0];
  assign near1_y_o      = n1_6_q[1];
  assign near1_z_o      = n1_6_q[2];

  // ---------------- assertions ----------------
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (thr_q == $past(pwdata)))
    else $error("threshold register missed a write");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("request did not produce a result after the pipeline latency");

  a_zero_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dres_vld && dres.lane[0].zero) |=> (s1_q == '0))
    else $error("forced-zero s lane produced a nonzero parameter");

  a_sat_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dres_vld && dres.lane[1].sat && !dres.lane[1].zero) |=> (t1_q == '1))
    else $error("saturated t lane did not clamp to all ones");

endmodule
